// ----- design/sobel_edge_magnitude_core_assert.svh -----
// Assertion macros shared by the edge magnitude core.
// With SYNTH defined every macro expands to nothing.
`ifndef SOBEL_EDGE_MAGNITUDE_CORE_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_CORE_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication: cons must hold whenever ante holds.
`define SEM_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sobel core: same-cycle check failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define SEM_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sobel core: next-cycle check failed");

`else

`define SEM_ASSERT_IMP(name, clk, rst, ante, cons)
`define SEM_ASSERT_NXT(name, clk, rst, ante, cons)

`endif

`endif

// ----- design/sem_pkg.sv -----
package sem_pkg;

  // Pixel and gradient widths
  localparam int PIX_W  = 8;
  localparam int GRAD_W = 11;

  // Configuration register widths and limits
  localparam int WIDTH_CFG_W  = 12;
  localparam int HEIGHT_CFG_W = 13;
  localparam int ROW_W        = 12;
  localparam int MIN_DIM      = 3;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  // Line store depth default
  localparam int MAX_WIDTH_DEFAULT = 2048;

  // Register port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Control travelling with a pixel from the line store read stage
  typedef struct packed {
    logic valid;
    logic interior;
    logic frame_last;
  } sem_ctl_t;

endpackage

// ----- design/sem_line_ram.sv -----
module sem_line_ram #(
  parameter int DEPTH = sem_pkg::MAX_WIDTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [sem_pkg::PIX_W-1:0] wdata,
  input  logic                     re,
  input  logic [AW-1:0]            raddr,
  output logic [sem_pkg::PIX_W-1:0] rdata
);

  logic [sem_pkg::PIX_W-1:0] mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/sem_grad.sv -----
module sem_grad (
  input  logic                              clk,
  input  logic                              rst,
  input  sem_pkg::sem_ctl_t                 in_ctl,
  input  logic [sem_pkg::PIX_W-1:0]         top,
  input  logic [sem_pkg::PIX_W-1:0]         mid,
  input  logic [sem_pkg::PIX_W-1:0]         bot,
  output logic                              in_ready,
  output logic                              out_valid,
  output logic signed [sem_pkg::GRAD_W-1:0] gx,
  output logic signed [sem_pkg::GRAD_W-1:0] gy,
  output logic                              out_last,
  input  logic                              out_ready
);

  localparam int SUM_W = sem_pkg::PIX_W + 2;

  // Left column (top, middle, bottom) then centre column
  logic [sem_pkg::PIX_W-1:0] win [6];

  logic              fire;
  logic [SUM_W-1:0]  gx_pos;
  logic [SUM_W-1:0]  gx_neg;
  logic [SUM_W-1:0]  gy_pos;
  logic [SUM_W-1:0]  gy_neg;
  logic [sem_pkg::GRAD_W-1:0] gx_next;
  logic [sem_pkg::GRAD_W-1:0] gy_next;

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_ctl.valid && in_ready;

  // Weighted column and row sums of the 3x3 neighbourhood
  always_comb begin
    gx_pos  = SUM_W'(top) + {1'b0, mid, 1'b0} + SUM_W'(bot);
    gx_neg  = SUM_W'(win[0]) + {1'b0, win[1], 1'b0} + SUM_W'(win[2]);
    gy_pos  = SUM_W'(win[2]) + {1'b0, win[5], 1'b0} + SUM_W'(bot);
    gy_neg  = SUM_W'(win[0]) + {1'b0, win[3], 1'b0} + SUM_W'(top);
    gx_next = sem_pkg::GRAD_W'(gx_pos) - sem_pkg::GRAD_W'(gx_neg);
    gy_next = sem_pkg::GRAD_W'(gy_pos) - sem_pkg::GRAD_W'(gy_neg);
  end

  // Shift the window by one column per pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (fire) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top;
      win[4] <= mid;
      win[5] <= bot;
    end
  end

  // Hold gradients for the magnitude stage; border pixels leave no word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= fire && in_ctl.interior;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      gx       <= $signed(gx_next);
      gy       <= $signed(gy_next);
      out_last <= in_ctl.frame_last;
    end
  end

endmodule

// ----- design/sem_mag.sv -----
module sem_mag (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic signed [sem_pkg::GRAD_W-1:0] gx,
  input  logic signed [sem_pkg::GRAD_W-1:0] gy,
  input  logic                              in_last,
  output logic                              in_ready,
  output logic                              out_valid,
  output logic [sem_pkg::PIX_W-1:0]         edge_strength,
  output logic                              out_last,
  input  logic                              out_ready
);

  localparam int ABS_W = sem_pkg::GRAD_W - 1;
  localparam int MAG_W = sem_pkg::GRAD_W;
  localparam logic [MAG_W-1:0] MAG_MAX = MAG_W'((1 << sem_pkg::PIX_W) - 1);

  logic [ABS_W-1:0] ax;
  logic [ABS_W-1:0] ay;
  logic [MAG_W-1:0] mag;
  logic [sem_pkg::PIX_W-1:0] mag_sat;

  assign in_ready = !out_valid || out_ready;

  // L1 magnitude, saturated to the pixel range
  always_comb begin
    ax      = gx[sem_pkg::GRAD_W-1] ? ABS_W'(-gx) : ABS_W'(gx);
    ay      = gy[sem_pkg::GRAD_W-1] ? ABS_W'(-gy) : ABS_W'(gy);
    mag     = MAG_W'(ax) + MAG_W'(ay);
    mag_sat = (mag > MAG_MAX) ? MAG_MAX[sem_pkg::PIX_W-1:0] : mag[sem_pkg::PIX_W-1:0];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      edge_strength <= mag_sat;
      out_last      <= in_last;
    end
  end

endmodule

// ----- design/sobel_edge_magnitude_core.sv -----
// Channel   Dir  Fields (lowest bit up)            Handshake
// s_*       in   tdata[7:0] pixel                  s_tvalid / s_tready
// m_*       out  tdata[7:0] edge_strength, tlast   m_tvalid / m_tready
// APB       in   0x0 image_width, 0x4 image_height psel/penable/pwrite, pready=1
//
// One pixel per cycle sustained while m_tready stays high; a result word reaches
// the output through the registered line store read, the gradient stage and the
// magnitude output register. Each stage stalls only when the one after it is
// full and not draining. rst (synchronous) clears counters, window and stage
// valid bits; line stores need no clearing since each entry is written on the
// row before it is read.
module sobel_edge_magnitude_core #(
  parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // Pixel stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] pixel
  // Edge stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [7:0]                      m_tdata,   // [7:0] edge_strength
  output logic                            m_tlast,   // frame_last
  // Register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sem_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [sem_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [sem_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  `include "sobel_edge_magnitude_core_assert.svh"

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (WW > sem_pkg::WIDTH_CFG_W) ? WW : sem_pkg::WIDTH_CFG_W;
  localparam int HW   = sem_pkg::HEIGHT_CFG_W;

  // Registers
  logic [sem_pkg::WIDTH_CFG_W-1:0]  image_width;
  logic [sem_pkg::HEIGHT_CFG_W-1:0] image_height;

  // Position of the next pixel
  logic [CW-1:0]             col;
  logic [sem_pkg::ROW_W-1:0] row;

  logic [CMPW-1:0] w_used;
  logic [HW-1:0]   h_used;
  logic            row_end;
  logic            frame_end;
  logic            interior;
  logic            s_accept;
  logic            cfg_write;

  // Line store read stage
  sem_pkg::sem_ctl_t          s1_ctl;
  logic [sem_pkg::PIX_W-1:0]  s1_pixel;
  logic [CW-1:0]              s1_idx;
  logic                       s1_go;
  logic                       s1_fire;
  logic [sem_pkg::PIX_W-1:0]  upper_rd;
  logic [sem_pkg::PIX_W-1:0]  middle_rd;

  // Gradient to magnitude
  logic                              s2_valid;
  logic signed [sem_pkg::GRAD_W-1:0] s2_gx;
  logic signed [sem_pkg::GRAD_W-1:0] s2_gy;
  logic                              s2_last;
  logic                              s2_ready;

  // Register port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= sem_pkg::WIDTH_CFG_W'(sem_pkg::WIDTH_RESET);
      image_height <= sem_pkg::HEIGHT_CFG_W'(sem_pkg::HEIGHT_RESET);
    end else if (cfg_write) begin
      unique case (paddr[2])
        sem_pkg::REG_WIDTH:  image_width  <= pwdata[sem_pkg::WIDTH_CFG_W-1:0];
        sem_pkg::REG_HEIGHT: image_height <= pwdata[sem_pkg::HEIGHT_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      sem_pkg::REG_WIDTH:  prdata = sem_pkg::APB_DATA_W'(image_width);
      sem_pkg::REG_HEIGHT: prdata = sem_pkg::APB_DATA_W'(image_height);
      default:             prdata = '0;
    endcase
  end

  // Clamp geometry and decode position of the incoming pixel
  always_comb begin
    priority if (CMPW'(image_width) < CMPW'(sem_pkg::MIN_DIM)) begin
      w_used = CMPW'(sem_pkg::MIN_DIM);
    end else if (CMPW'(image_width) > CMPW'(MAX_WIDTH)) begin
      w_used = CMPW'(MAX_WIDTH);
    end else begin
      w_used = CMPW'(image_width);
    end
    priority if (image_height < HW'(sem_pkg::MIN_DIM)) begin
      h_used = HW'(sem_pkg::MIN_DIM);
    end else if (image_height > HW'(sem_pkg::HEIGHT_LIMIT)) begin
      h_used = HW'(sem_pkg::HEIGHT_LIMIT);
    end else begin
      h_used = image_height;
    end
    row_end   = (CMPW'(col) + CMPW'(1)) >= w_used;
    frame_end = row_end && ((HW'(row) + HW'(1)) >= h_used);
    interior  = (row >= sem_pkg::ROW_W'(2)) && (col >= CW'(2));
  end

  assign s_tready = !s1_ctl.valid || s1_go;
  assign s_accept = s_tvalid && s_tready;
  assign s1_fire  = s1_ctl.valid && s1_go;

  // Advance raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (s_accept) begin
      if (row_end) begin
        col <= '0;
        row <= frame_end ? '0 : row + sem_pkg::ROW_W'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  // Hold the pixel while its line store words are read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else if (s_accept) begin
      s1_ctl <= '{valid: 1'b1, interior: interior, frame_last: frame_end};
    end else if (s1_fire) begin
      s1_ctl.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_pixel <= s_tdata;
      s1_idx   <= col;
    end
  end

  // Line stores: read on accept, write back as the pixel leaves the stage
  sem_line_ram #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_upper (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_idx),
    .wdata (middle_rd),
    .re    (s_accept),
    .raddr (col),
    .rdata (upper_rd)
  );

  sem_line_ram #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_middle (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_idx),
    .wdata (s1_pixel),
    .re    (s_accept),
    .raddr (col),
    .rdata (middle_rd)
  );

  sem_grad u_grad (
    .clk       (clk),
    .rst       (rst),
    .in_ctl    (s1_ctl),
    .top       (upper_rd),
    .mid       (middle_rd),
    .bot       (s1_pixel),
    .in_ready  (s1_go),
    .out_valid (s2_valid),
    .gx        (s2_gx),
    .gy        (s2_gy),
    .out_last  (s2_last),
    .out_ready (s2_ready)
  );

  sem_mag u_mag (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s2_valid),
    .gx            (s2_gx),
    .gy            (s2_gy),
    .in_last       (s2_last),
    .in_ready      (s2_ready),
    .out_valid     (m_tvalid),
    .edge_strength (m_tdata),
    .out_last      (m_tlast),
    .out_ready     (m_tready)
  );

  // Checks
  `SEM_ASSERT_NXT(a_row_wrap, clk, rst, s_accept && row_end, col == '0)
  `SEM_ASSERT_NXT(a_frame_wrap, clk, rst, s_accept && frame_end, row == '0)
  `SEM_ASSERT_IMP(a_empty_takes, clk, rst, !s1_ctl.valid, s_tready)
  `SEM_ASSERT_NXT(a_stage_hold, clk, rst, s1_ctl.valid && !s1_go, s1_ctl.valid && $stable(s1_idx))
  `SEM_ASSERT_IMP(a_no_rw_clash, clk, rst, s_accept && s1_fire, col != s1_idx)

endmodule

// ----- tb/sobel_edge_magnitude_core_tb.sv -----
module sobel_edge_magnitude_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W      = sem_pkg::MAX_WIDTH_DEFAULT;
  localparam int STALL_PCT  = 73;
  localparam int BOTH_PCT   = 25;
  localparam int HOLD_LEN   = 400;
  localparam int SETTLE_LEN = 8;
  localparam int IDLE_LIMIT = 5000;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [sem_pkg::PIX_W-1:0] strength;
    logic                      last;
  } edge_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [7:0]                      s_tdata = '0;   // [7:0] pixel
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [7:0]                      m_tdata;        // [7:0] edge_strength
  logic                            m_tlast;        // frame_last
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [sem_pkg::APB_ADDR_W-1:0]  paddr = '0;
  logic [sem_pkg::APB_DATA_W-1:0]  pwdata = '0;
  logic [sem_pkg::APB_DATA_W-1:0]  prdata;
  logic                            pready;

  // Pending pixels and expected edge words
  logic [sem_pkg::PIX_W-1:0] pixel_q[$];
  edge_word_t                edge_q[$];

  // Shadow of the block's geometry and pixel history
  logic [sem_pkg::WIDTH_CFG_W-1:0]  width_reg =
      sem_pkg::WIDTH_CFG_W'(sem_pkg::WIDTH_RESET);
  logic [sem_pkg::HEIGHT_CFG_W-1:0] height_reg =
      sem_pkg::HEIGHT_CFG_W'(sem_pkg::HEIGHT_RESET);
  logic [sem_pkg::PIX_W-1:0]        upper_line [MAX_W];
  logic [sem_pkg::PIX_W-1:0]        middle_line [MAX_W];
  logic [sem_pkg::PIX_W-1:0]        win_px [6] = '{default: '0};
  int unsigned                      pred_col = 0;
  int unsigned                      pred_row = 0;

  idle_mode_t idle_mode = IDLE_NONE;
  bit         hold_on = 1'b0;
  bit         pix_taken = 1'b0;
  int         idle_cycles = 0;
  int         err_count = 0;

  sobel_edge_magnitude_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit take_gap(input bit sender);
    case (idle_mode)
      IDLE_SEND: return sender && ($urandom_range(99) < STALL_PCT);
      IDLE_RECV: return !sender && ($urandom_range(99) < STALL_PCT);
      IDLE_BOTH: return $urandom_range(99) < BOTH_PCT;
      default:   return 1'b0;
    endcase
  endfunction

  // Bias towards black and white so saturation is reached often
  function automatic logic [sem_pkg::PIX_W-1:0] pick_pixel();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return sem_pkg::PIX_W'($urandom_range(255));
    endcase
  endfunction

  // Advance the shadow by one pixel and queue the edge word it yields
  function automatic void predict_edge(input logic [sem_pkg::PIX_W-1:0] pix);
    int unsigned w, h, c, r, idx;
    int top, mid, bot, tl, ml, bl, tc, bc, gx, gy, mag;
    bit row_end, frame_end;
    edge_word_t word;
    w = (width_reg < sem_pkg::MIN_DIM) ? sem_pkg::MIN_DIM :
        (width_reg > MAX_W) ? MAX_W : width_reg;
    h = (height_reg < sem_pkg::MIN_DIM) ? sem_pkg::MIN_DIM :
        (height_reg > sem_pkg::HEIGHT_LIMIT) ? sem_pkg::HEIGHT_LIMIT : height_reg;
    c = pred_col;
    r = pred_row;
    idx = (c < MAX_W) ? c : MAX_W - 1;
    bot = int'(pix);
    top = int'(upper_line[idx]);
    mid = int'(middle_line[idx]);
    tl = int'(win_px[0]);
    ml = int'(win_px[1]);
    bl = int'(win_px[2]);
    tc = int'(win_px[3]);
    bc = int'(win_px[5]);
    row_end = (c + 1 >= w);
    frame_end = row_end && (r + 1 >= h);
    if (r >= 2 && c >= 2) begin
      gx = (top + 2 * mid + bot) - (tl + 2 * ml + bl);
      gy = (bl + 2 * bc + bot) - (tl + 2 * tc + top);
      mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
      if (mag > 255) mag = 255;
      word.strength = mag[sem_pkg::PIX_W-1:0];
      word.last = frame_end;
      edge_q.push_back(word);
    end
    // Shift the window left by one column
    win_px[0] = win_px[3];
    win_px[1] = win_px[4];
    win_px[2] = win_px[5];
    win_px[3] = top[sem_pkg::PIX_W-1:0];
    win_px[4] = mid[sem_pkg::PIX_W-1:0];
    win_px[5] = pix;
    upper_line[idx] = mid[sem_pkg::PIX_W-1:0];
    middle_line[idx] = pix;
    if (row_end) begin
      pred_col = 0;
      pred_row = frame_end ? 0 : r + 1;
    end else begin
      pred_col = c + 1;
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch: %s got %0d want %0d", $realtime, what, got, want);
    err_count++;
  endtask

  // Pixel driver: hold a word until taken, then offer the next or idle
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!(s_tvalid && !pix_taken)) begin
      if (pixel_q.size() > 0 && !take_gap(1'b1)) begin
        s_tdata <= pixel_q.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Edge receiver
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !hold_on && !take_gap(1'b0);
    end
  end

  // Monitor: predict on each pixel taken, check each edge word, watch for a hang
  always @(posedge clk) begin
    edge_word_t want;
    if (rst) begin
      pix_taken <= 1'b0;
      idle_cycles <= 0;
    end else begin
      pix_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) predict_edge(s_tdata);
      if (m_tvalid && m_tready) begin
        if (edge_q.size() == 0) begin
          report_mismatch("unexpected edge word", int'(m_tdata), -1);
        end else begin
          want = edge_q.pop_front();
          if (m_tdata !== want.strength)
            report_mismatch("edge_strength", int'(m_tdata), int'(want.strength));
          if (m_tlast !== want.last)
            report_mismatch("frame_last", int'(m_tlast), int'(want.last));
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("sobel_edge_magnitude_core_tb: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic step_cycle();
    @(posedge clk);
    #1;
  endtask

  task automatic write_reg(input logic idx, input logic [sem_pkg::APB_DATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == sem_pkg::REG_WIDTH) width_reg = value[sem_pkg::WIDTH_CFG_W-1:0];
    else height_reg = value[sem_pkg::HEIGHT_CFG_W-1:0];
  endtask

  task automatic set_geometry(input int w, input int h);
    write_reg(sem_pkg::REG_WIDTH, w);
    write_reg(sem_pkg::REG_HEIGHT, h);
    step_cycle();
  endtask

  task automatic queue_random(input int n);
    repeat (n) pixel_q.push_back(pick_pixel());
  endtask

  // Wait until every pixel is taken and every edge word has come, then settle
  task automatic drain();
    do step_cycle();
    while (pixel_q.size() != 0 || s_tvalid || edge_q.size() != 0);
    repeat (SETTLE_LEN) step_cycle();
  endtask

  initial begin
    rst = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    step_cycle();

    // Smallest frame: flat white, a right-hand white edge, a top white edge
    set_geometry(sem_pkg::MIN_DIM, sem_pkg::MIN_DIM);
    for (int f = 0; f < 3; f++)
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          case (f)
            0:       pixel_q.push_back(8'hFF);
            1:       pixel_q.push_back(c == 2 ? 8'hFF : 8'h00);
            default: pixel_q.push_back(r == 0 ? 8'hFF : 8'h00);
          endcase
    drain();

    // Undersized geometry clamps to the minimum
    idle_mode = IDLE_SEND;
    set_geometry(0, 2);
    queue_random(27);
    drain();

    idle_mode = IDLE_RECV;
    set_geometry(5, 4);
    queue_random(80);
    drain();

    // Long receiver hold-off with the sender still offering
    idle_mode = IDLE_NONE;
    set_geometry(4, 5);
    queue_random(100);
    hold_on = 1'b1;
    repeat (HOLD_LEN) step_cycle();
    hold_on = 1'b0;
    drain();

    // Oversized height, then cut the frame short mid-way
    idle_mode = IDLE_BOTH;
    set_geometry(7, 8191);
    queue_random(35);
    drain();
    write_reg(sem_pkg::REG_HEIGHT, sem_pkg::MIN_DIM);
    step_cycle();
    queue_random(7 + 21);
    drain();

    // Mid-sized frames under every idling pattern
    set_geometry(8, 4);
    for (int m = 0; m < 4; m++) begin
      idle_mode = idle_mode_t'(m);
      queue_random(32);
      drain();
    end

    if (err_count == 0) begin
      $display("sobel_edge_magnitude_core_tb: clean");
    end else begin
      $display("sobel_edge_magnitude_core_tb: errors");
    end
    $finish;
  end

endmodule
